// ===== rtl/ddds_pkg.sv =====
`timescale 1ns / 1ps

package ddds_pkg;

  localparam int SAMPLE_RATE_DEF = 44100;
  localparam int SINE_DEPTH_DEF  = 1024;

  localparam int SMP_W      = 16;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 17;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 62;
  localparam int MAG_W      = 47;
  localparam int MAG_LO_W   = 23;
  localparam int FREQ_W     = 23;
  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 49;
  localparam int DIV_Q_W    = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_Q_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  localparam logic [MUL_B_W-1:0] W_FUND   = 17'd36045;
  localparam logic [MUL_B_W-1:0] W_SECOND = 17'd19661;
  localparam logic [MUL_B_W-1:0] W_THIRD  = 17'd9830;

  localparam logic [FREQ_W-1:0] FREQ_BASE = 23'd4259840;

  localparam logic [14:0] FLOOR_RST   = 15'd4915;
  localparam logic [14:0] CEIL_RST    = 15'd14746;
  localparam logic [15:0] FALLOFF_RST = 16'd1966;
  localparam logic [15:0] SMOOTH_RST  = 16'd3277;
  localparam logic [14:0] GAIN_RST    = 15'd24000;
  localparam logic [15:0] VOL_RST     = 16'd4915;

  localparam logic [1:0] HARM_FUND  = 2'd0;
  localparam logic [1:0] HARM_SECOND = 2'd1;
  localparam logic [1:0] HARM_LAST  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUM_FLOOR   = 3'd0,
    CFG_HUM_CEILING = 3'd1,
    CFG_FALLOFF     = 3'd2,
    CFG_SMOOTHING   = 3'd3,
    CFG_OUT_GAIN    = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_F_DX,
    ST_F_DY,
    ST_F_SUM,
    ST_F_FO,
    ST_F_DEN,
    ST_F_RCP,
    ST_F_ERR,
    ST_F_VOL,
    ST_F_STP,
    ST_T_IDX,
    ST_T_ROM,
    ST_T_WGT,
    ST_T_ACC,
    ST_T_VOL,
    ST_T_CLP,
    ST_T_GHI,
    ST_T_GLO,
    ST_T_OUT,
    ST_T_PUSH
  } ddds_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

endpackage

// ===== rtl/ddds_if.sv =====
`timescale 1ns / 1ps

interface ddds_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] dx_to_exit;
  logic signed [15:0] dy_to_exit;

  modport source (output valid, output req_type, output dx_to_exit, output dy_to_exit,
                  input ready);
  modport sink (input valid, input req_type, input dx_to_exit, input dy_to_exit,
                output ready);
endinterface

interface ddds_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== rtl/ddds_sine_rom.sv =====
`timescale 1ns / 1ps

module ddds_sine_rom import ddds_pkg::*; #(
  parameter int DEPTH = SINE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  output logic signed [SMP_W-1:0]    rd_data_r
);

  function automatic logic [DEPTH*SMP_W-1:0] build_rom();
    logic [DEPTH*SMP_W-1:0] tbl;
    logic [63:0]            quad;
    logic [63:0]            r;
    logic [63:0]            x;
    logic [63:0]            s;
    logic [63:0]            v;
    tbl = '0;
    for (int k = 0; k < DEPTH; k++) begin
      quad = 64'((4 * k) / DEPTH);
      r    = 64'((4 * k) % DEPTH);
      if (quad[0]) begin
        r = 64'(DEPTH) - r;
      end
      x = (PI_HALF_Q30 * r) / DEPTH;
      s = sine_q30(x);
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      if (quad >= 64'd2) begin
        tbl[k*SMP_W +: SMP_W] = -SMP_W'(v);
      end else begin
        tbl[k*SMP_W +: SMP_W] = SMP_W'(v);
      end
    end
    return tbl;
  endfunction

  localparam logic [DEPTH*SMP_W-1:0] ROM_C = build_rom();

  always_ff @(posedge clk) begin
    rd_data_r <= ROM_C[addr*SMP_W +: SMP_W];
  end

endmodule

// ===== rtl/ddds_mul.sv =====
`timescale 1ns / 1ps

module ddds_mul import ddds_pkg::*; (
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0]  b,
  output logic signed [MUL_P_W-1:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ===== rtl/ddds_div.sv =====
`timescale 1ns / 1ps

module ddds_div import ddds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVISOR_W-1:0] rem_r;
  logic [DIV_Q_W-1:0]   dq_r;
  logic [DIVISOR_W-1:0] dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign trial = {rem_r, dq_r[DIV_Q_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= DIVISOR_W'(req.dividend[DIVIDEND_W-1:DIV_Q_W]);
      dq_r  <= req.dividend[DIV_Q_W-1:0];
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      dq_r  <= {dq_r[DIV_Q_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dq_r;

endmodule

// ===== rtl/distance_driven_drone_synth.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                                   Transfer
// in_chan   in   req_type, dx_to_exit, dy_to_exit          valid && ready
// out_chan  out  sample_out                                valid && ready
// cfg_*     in   cfg_index, cfg_wdata                      cfg_we high
//
// A frame update makes two 32-step passes of the shared restoring divider
// (reciprocal, then phase step); it produces no result. A sample tick reaches
// the output register after its harmonic, volume, clip, gain and output steps;
// the single shared multiplier handles index, harmonic, volume and gain products.
// in_chan.ready is high only while the sequencer is idle. A full output register
// holds the sequencer until out_chan takes the sample. Reset is synchronous.

module distance_driven_drone_synth import ddds_pkg::*; #(
  parameter int SAMPLE_RATE      = SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ddds_in_if.sink               in_chan,
  ddds_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam logic [63:0] STEP_RST_L = (64'd70 << 32) / SAMPLE_RATE;
  localparam logic [31:0] STEP_RST = STEP_RST_L[31:0];

  ddds_state_t state_r, state_nxt;

  logic [14:0] floor_r, ceil_r, gain_r;
  logic [15:0] falloff_r, smooth_r;
  logic [31:0] phase_r, step_r;
  logic [15:0] vol_r;

  logic signed [15:0]      dx_r, dy_r;
  logic [ACC_W-1:0]        acc_r;
  logic [14:0]             tgt_r;
  logic                    neg_r;
  logic [1:0]              harm_r;
  logic signed [SMP_W-1:0] smp_r;
  logic                    out_valid_r;
  logic signed [SMP_W-1:0] out_smp_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic signed [SMP_W-1:0]   rom_q;
  logic                      in_rdy;

  logic                      in_xfer;
  logic                      out_free;
  logic [ACC_W-1:0]          p_ext;
  logic [DIVISOR_W-1:0]      den;
  logic [16:0]               tgt_sum;
  logic [14:0]               tgt_sel;
  logic [16:0]               err;
  logic [FREQ_W-1:0]         freq;
  logic [31:0]               ph2, ph3, ph_sel;
  logic [MUL_B_W-1:0]        w_sel;
  logic [MUL_P_W-1:0]        prod_abs;
  logic [MAG_W-1:0]          mag;
  logic [ACC_W-1:0]          gsum;
  logic [14:0]               res;

  ddds_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  ddds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ddds_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk       (clk),
    .addr      (mul_p[32 +: IDX_W]),
    .rd_data_r (rom_q)
  );

  assign in_xfer  = in_chan.valid && in_rdy;
  assign out_free = !out_valid_r || out_chan.ready;
  assign p_ext    = {{(ACC_W - MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
  assign den      = {1'b0, mul_p[DIVIDEND_W-1:0]} + (DIVISOR_W'(1) << 32);
  assign tgt_sum  = {2'b00, floor_r} + {1'b0, div_rsp.quot[15:0]};
  assign tgt_sel  = (tgt_sum > {2'b00, ceil_r}) ? ceil_r : tgt_sum[14:0];
  assign err      = {2'b00, tgt_r} - {1'b0, vol_r};
  assign freq     = FREQ_BASE + ({8'b0, tgt_r} << 6) - ({8'b0, tgt_r} << 2);
  assign ph2      = {phase_r[30:0], 1'b0};
  assign ph3      = phase_r + ph2;
  assign prod_abs = mul_p[MUL_P_W-1] ? -mul_p : mul_p;
  assign mag      = (prod_abs > (MUL_P_W'(1) << (MAG_W - 1))) ?
                    (MAG_W'(1) << (MAG_W - 1)) : prod_abs[MAG_W-1:0];
  assign gsum     = acc_r + {{(ACC_W - MUL_P_W){1'b0}}, mul_p};
  assign res      = gsum[MAG_W+13:MAG_W-1];

  always_comb begin
    case (harm_r)
      HARM_FUND: begin
        ph_sel = phase_r;
        w_sel  = W_FUND;
      end
      HARM_SECOND: begin
        ph_sel = ph2;
        w_sel  = W_SECOND;
      end
      default: begin
        ph_sel = ph3;
        w_sel  = W_THIRD;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_chan.valid) state_nxt = in_chan.req_type ? ST_T_IDX : ST_F_DX;
      ST_F_DX:   state_nxt = ST_F_DY;
      ST_F_DY:   state_nxt = ST_F_SUM;
      ST_F_SUM:  state_nxt = ST_F_FO;
      ST_F_FO:   state_nxt = ST_F_DEN;
      ST_F_DEN:  state_nxt = ST_F_RCP;
      ST_F_RCP:  if (div_rsp.done) state_nxt = ST_F_ERR;
      ST_F_ERR:  state_nxt = ST_F_VOL;
      ST_F_VOL:  state_nxt = ST_F_STP;
      ST_F_STP:  if (div_rsp.done) state_nxt = ST_IDLE;
      ST_T_IDX:  state_nxt = ST_T_ROM;
      ST_T_ROM:  state_nxt = ST_T_WGT;
      ST_T_WGT:  state_nxt = ST_T_ACC;
      ST_T_ACC:  state_nxt = (harm_r == HARM_LAST) ? ST_T_VOL : ST_T_IDX;
      ST_T_VOL:  state_nxt = ST_T_CLP;
      ST_T_CLP:  state_nxt = ST_T_GHI;
      ST_T_GHI:  state_nxt = ST_T_GLO;
      ST_T_GLO:  state_nxt = ST_T_OUT;
      ST_T_OUT:  state_nxt = ST_T_PUSH;
      ST_T_PUSH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    unique case (state_r)
      ST_IDLE: in_rdy = 1'b1;
      ST_F_DX: begin
        mul_a = {{(MUL_A_W - 16){dx_r[15]}}, dx_r};
        mul_b = {dx_r[15], dx_r};
      end
      ST_F_DY: begin
        mul_a = {{(MUL_A_W - 16){dy_r[15]}}, dy_r};
        mul_b = {dy_r[15], dy_r};
      end
      ST_F_FO: begin
        mul_a = {2'b00, acc_r[31:0]};
        mul_b = {1'b0, falloff_r};
      end
      ST_F_DEN: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVIDEND_W'(1) << (DIVIDEND_W - 1);
        div_req.divisor  = den;
      end
      ST_F_ERR: begin
        mul_a = {{(MUL_A_W - 17){err[16]}}, err};
        mul_b = {1'b0, smooth_r};
      end
      ST_F_VOL: begin
        div_req.start    = 1'b1;
        div_req.dividend = {8'b0, freq, 17'b0};
        div_req.divisor  = DIVISOR_W'(SAMPLE_RATE);
      end
      ST_T_IDX: begin
        mul_a = {2'b00, ph_sel};
        mul_b = MUL_B_W'(SINE_TABLE_DEPTH);
      end
      ST_T_WGT: begin
        mul_a = {{(MUL_A_W - SMP_W){rom_q[SMP_W-1]}}, rom_q};
        mul_b = w_sel;
      end
      ST_T_VOL: begin
        mul_a = {{2{acc_r[31]}}, acc_r[31:0]};
        mul_b = {1'b0, vol_r};
      end
      ST_T_GHI: begin
        mul_a = {10'b0, acc_r[MAG_W-1:MAG_LO_W]};
        mul_b = {2'b00, gain_r};
      end
      ST_T_GLO: begin
        mul_a = {11'b0, acc_r[MAG_LO_W-1:0]};
        mul_b = {2'b00, gain_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      floor_r     <= FLOOR_RST;
      ceil_r      <= CEIL_RST;
      falloff_r   <= FALLOFF_RST;
      smooth_r    <= SMOOTH_RST;
      gain_r      <= GAIN_RST;
      phase_r     <= '0;
      step_r      <= STEP_RST;
      vol_r       <= VOL_RST;
      harm_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_HUM_FLOOR:   floor_r   <= cfg_wdata[14:0];
          CFG_HUM_CEILING: ceil_r    <= cfg_wdata[14:0];
          CFG_FALLOFF:     falloff_r <= cfg_wdata;
          CFG_SMOOTHING:   smooth_r  <= cfg_wdata;
          CFG_OUT_GAIN:    gain_r    <= cfg_wdata[14:0];
          default: begin
          end
        endcase
      end
      if (in_xfer) harm_r <= '0;
      if (state_r == ST_T_ACC) harm_r <= harm_r + 2'd1;
      if (state_r == ST_F_VOL) vol_r <= vol_r + mul_p[31:16];
      if (state_r == ST_F_STP && div_rsp.done) step_r <= div_rsp.quot;
      if (state_r == ST_T_CLP) phase_r <= phase_r + step_r;
      if (out_chan.ready) out_valid_r <= 1'b0;
      if (state_r == ST_T_PUSH && out_free) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dx_r  <= in_chan.dx_to_exit;
      dy_r  <= in_chan.dy_to_exit;
      acc_r <= '0;
    end
    unique case (state_r)
      ST_F_DY:  acc_r <= p_ext;
      ST_F_SUM: acc_r <= acc_r + p_ext;
      ST_F_RCP: if (div_rsp.done) tgt_r <= tgt_sel;
      ST_T_ACC: acc_r <= acc_r + p_ext;
      ST_T_CLP: begin
        acc_r <= {{(ACC_W - MAG_W){1'b0}}, mag};
        neg_r <= mul_p[MUL_P_W-1];
      end
      ST_T_GLO: acc_r <= {mul_p[ACC_W-MAG_LO_W-1:0], {MAG_LO_W{1'b0}}};
      ST_T_OUT: smp_r <= neg_r ? -{1'b0, res} : {1'b0, res};
      ST_T_PUSH: if (out_free) out_smp_r <= smp_r;
      default: begin
      end
    endcase
  end

  assign in_chan.ready       = in_rdy;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_smp_r;

  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n) !vol_r[15])
    else $error("volume left the Q1.15 range");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_F_RCP || state_r == ST_F_STP))
    else $error("divider finished outside a wait state");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_T_CLP) |=> $stable(phase_r))
    else $error("phase moved outside its advance step");

endmodule

// ===== verif/tb_distance_driven_drone_synth.sv =====
`timescale 1ns / 1ps

module tb_distance_driven_drone_synth;
  import ddds_pkg::*;

  localparam int TB_RATE = SAMPLE_RATE_DEF;
  localparam int TB_DEPTH = SINE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_TICK = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  localparam longint WT_FUND = 36045;
  localparam longint WT_SECOND = 19661;
  localparam longint WT_THIRD = 9830;
  localparam longint UNIT_Q46 = longint'(1) << 46;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } drone_req_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ddds_in_if in_chan();
  ddds_out_if out_chan();

  distance_driven_drone_synth dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  logic signed [15:0] sine_tab [TB_DEPTH];

  logic [14:0] hum_floor_q15;
  logic [14:0] hum_ceil_q15;
  logic [15:0] falloff_q16;
  logic [15:0] smooth_q16;
  logic [14:0] gain_scale;
  logic [31:0] osc_ph;
  logic [31:0] osc_inc;
  logic [15:0] drone_vol;

  drone_req_t pending_reqs[$];
  logic signed [15:0] expected_samples[$];
  drone_req_t cur_req;
  logic signed [15:0] want_smp;
  int mismatches = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  logic quiet = 1'b0;

  function automatic longint rom_lookup(input logic [31:0] ph);
    logic [63:0] idx;
    idx = ({32'd0, ph} * TB_DEPTH) >> 32;
    return longint'(sine_tab[idx]);
  endfunction

  task automatic predict_request(input drone_req_t r);
    longint dxl, dyl, err, delta, vol_l, coef_l, mix, prod;
    logic [63:0] d2, den, tgt, freq, mag;
    logic [31:0] p, p2, p3;
    logic neg;
    if (r.req_type == REQ_FRAME) begin
      dxl = r.dx;
      dyl = r.dy;
      d2 = 64'(dxl * dxl) + 64'(dyl * dyl);
      den = (64'd1 << 32) + {48'd0, falloff_q16} * d2;
      tgt = (64'd1 << 47) / den + {49'd0, hum_floor_q15};
      if (tgt > {49'd0, hum_ceil_q15}) tgt = {49'd0, hum_ceil_q15};
      vol_l = drone_vol;
      coef_l = smooth_q16;
      err = longint'(tgt) - vol_l;
      delta = (err * coef_l) >>> 16;
      drone_vol = 16'(vol_l + delta);
      freq = {41'd0, FREQ_BASE} + 64'd60 * tgt;
      osc_inc = 32'((freq << 17) / TB_RATE);
    end else begin
      p = osc_ph;
      p2 = p << 1;
      p3 = p2 + p;
      mix = rom_lookup(p) * WT_FUND + rom_lookup(p2) * WT_SECOND + rom_lookup(p3) * WT_THIRD;
      vol_l = drone_vol;
      prod = mix * vol_l;
      neg = prod < 0;
      osc_ph = p + osc_inc;
      if (prod > UNIT_Q46) prod = UNIT_Q46;
      if (prod < -UNIT_Q46) prod = -UNIT_Q46;
      mag = neg ? 64'(-prod) : 64'(prod);
      mag = (mag * gain_scale) >> 46;
      expected_samples.push_back(neg ? -16'(mag) : 16'(mag));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_HUM_FLOOR:   hum_floor_q15 = val[14:0];
      CFG_HUM_CEILING: hum_ceil_q15 = val[14:0];
      CFG_FALLOFF:     falloff_q16 = val;
      CFG_SMOOTHING:   smooth_q16 = val;
      CFG_OUT_GAIN:    gain_scale = val[14:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] fl, input logic [15:0] ce,
                               input logic [15:0] fo, input logic [15:0] sm,
                               input logic [15:0] ga);
    write_reg(CFG_HUM_FLOOR, fl);
    write_reg(CFG_HUM_CEILING, ce);
    write_reg(CFG_FALLOFF, fo);
    write_reg(CFG_SMOOTHING, sm);
    write_reg(CFG_OUT_GAIN, ga);
    write_reg(CFG_IDX_UNUSED, 16'($urandom));
  endtask

  task automatic queue_frame(input logic signed [15:0] dx, input logic signed [15:0] dy);
    drone_req_t it;
    it.req_type = REQ_FRAME;
    it.dx = dx;
    it.dy = dy;
    pending_reqs.push_back(it);
  endtask

  task automatic queue_tick();
    drone_req_t it;
    it.req_type = REQ_TICK;
    it.dx = 16'($urandom);
    it.dy = 16'($urandom);
    pending_reqs.push_back(it);
  endtask

  task automatic queue_random(input int count);
    drone_req_t it;
    for (int i = 0; i < count; i++) begin
      it.req_type = ($urandom_range(0, 3) != 0) ? REQ_TICK : REQ_FRAME;
      case ($urandom_range(0, 3))
        0, 1: begin
          it.dx = 16'($urandom_range(0, 2047) - 1024);
          it.dy = 16'($urandom_range(0, 2047) - 1024);
        end
        2: begin
          it.dx = 16'($urandom);
          it.dy = 16'($urandom);
        end
        default: begin
          it.dx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          it.dy = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
      endcase
      pending_reqs.push_back(it);
    end
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver: hold the payload while the transfer is pending
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!(in_chan.valid && !in_chan.ready)) begin
      if (in_chan.valid) begin
        cur_req = pending_reqs.pop_front();
        predict_request(cur_req);
      end
      if (!quiet && in_gap == 0 && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 12);
      if (in_gap > 0) begin
        in_gap--;
        in_chan.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_chan.valid <= 1'b1;
        in_chan.req_type <= pending_reqs[0].req_type;
        in_chan.dx_to_exit <= pending_reqs[0].dx;
        in_chan.dy_to_exit <= pending_reqs[0].dy;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!quiet && out_gap == 0 && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 12);
    if (out_gap > 0) begin
      out_gap--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample_out %0d", out_chan.sample_out);
      end else begin
        want_smp = expected_samples.pop_front();
        if (out_chan.sample_out !== want_smp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("sample_out mismatch: expected %0d actual %0d", want_smp,
                     out_chan.sample_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_distance_driven_drone_synth: errors");
      $finish;
    end
  end

  initial begin
    logic [63:0] x, x2, term, acc, v;
    int quad, r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_HUM_FLOOR;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.req_type = REQ_FRAME;
    in_chan.dx_to_exit = '0;
    in_chan.dy_to_exit = '0;
    out_chan.ready = 1'b0;

    for (int k = 0; k < TB_DEPTH; k++) begin
      quad = (4 * k) / TB_DEPTH;
      r = (4 * k) % TB_DEPTH;
      if (quad[0]) r = TB_DEPTH - r;
      x = (PI_HALF_Q30 * r) / TB_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 7; n++) begin
        term = (term * x2) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        acc = n[0] ? acc - term : acc + term;
      end
      v = (acc * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      sine_tab[k] = (quad >= 2) ? -16'(v) : 16'(v);
    end

    hum_floor_q15 = FLOOR_RST;
    hum_ceil_q15 = CEIL_RST;
    falloff_q16 = FALLOFF_RST;
    smooth_q16 = SMOOTH_RST;
    gain_scale = GAIN_RST;
    osc_ph = '0;
    osc_inc = 32'((64'd70 << 32) / TB_RATE);
    drone_vol = VOL_RST;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings
    queue_tick();
    queue_tick();
    queue_tick();
    queue_frame(16'sd0, 16'sd0);
    queue_tick();
    queue_tick();
    queue_frame(16'sh7FFF, 16'sh7FFF);
    queue_frame(16'sh8000, 16'sh8000);
    queue_frame(16'sh8000, 16'sh7FFF);
    queue_frame(16'sh7FFF, 16'sh8000);
    queue_tick();
    queue_frame(16'sd256, 16'sd0);
    queue_frame(16'sd0, -16'sd256);
    queue_frame(16'sd1, -16'sd1);
    queue_tick();
    queue_tick();
    queue_random(150);
    settle();

    // top of every range, masked bits set
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(16'sd0, 16'sd0);
    queue_tick();
    queue_frame(16'sh7FFF, 16'sh8000);
    queue_tick();
    queue_random(80);
    settle();
    queue_random(80);
    settle();

    // all zero: frozen volume, silent output
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_frame(16'sd0, 16'sd0);
    queue_tick();
    queue_random(60);
    settle();

    // no falloff: target saturates at the ceiling, fast smoothing
    load_settings(16'd1000, 16'd32767, 16'd0, 16'd65535, 16'd32767);
    queue_frame(16'sh7FFF, 16'sh7FFF);
    queue_tick();
    queue_tick();
    queue_random(100);
    settle();

    // floor above ceiling
    load_settings(16'd30000, 16'd8000, 16'($urandom), 16'($urandom), 16'($urandom));
    queue_frame(16'sd0, 16'sd0);
    queue_tick();
    queue_frame(16'sh8000, 16'sh8000);
    queue_tick();
    queue_random(120);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      load_settings(16'($urandom_range(0, 16383)), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
      if (ph == 2) quiet = 1'b1;
      queue_random(120);
      settle();
    end

    if (mismatches == 0) begin
      $display("tb_distance_driven_drone_synth: clean");
    end else begin
      $display("tb_distance_driven_drone_synth: errors");
    end
    $finish;
  end

endmodule
